>>> rtl/dmsl_pkg.sv
// Package for the dual motor serial link: event codes, result kinds,
// register indexes, reset constants and the result request passed to the serializer.
// No dependencies.
package dmsl_pkg;

  // Event carried by one input request
  typedef enum logic [1:0] {
    OP_CMD_BYTE  = 2'd0,
    OP_LEFT_EDGE = 2'd1,
    OP_RIGHT_EDGE = 2'd2,
    OP_MS_TICK   = 2'd3
  } op_e;

  // Kind of one output request
  typedef enum logic {
    KIND_MOTOR  = 1'b0,
    KIND_TELEM  = 1'b1
  } kind_e;

  // Configuration register indexes
  localparam logic [7:0] REG_SEND_PERIOD  = 8'd0;
  localparam logic [7:0] REG_FRAME_HEADER = 8'd1;

  // Reset values
  localparam logic [15:0] PERIOD_RESET = 16'd20;
  localparam logic [15:0] HEADER_RESET = 16'hABCD;
  localparam logic [15:0] LEFT_RESET   = 16'd1240;
  localparam logic [15:0] RIGHT_RESET  = 16'd3567;
  localparam logic [15:0] MS_MAX       = 16'hFFFF;

  // Command frame: four payload bytes, then the checksum
  localparam logic [2:0] CHECKSUM_POS = 3'd4;
  localparam logic [2:0] TELEM_LAST   = 3'd7;

  // Result handed from the event core to the serializer
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  left_pwm;
    logic [7:0]  right_pwm;
    logic        left_reverse;
    logic        right_reverse;
    logic [63:0] frame;          // telemetry bytes, byte k at [8k+7:8k]
  } res_t;

endpackage

>>> rtl/dual_motor_serial_link.sv
// Top level of the dual motor serial link: command decoder, encoder counters
// and telemetry framer. Depends on dmsl_pkg, dmsl_in_reg, dmsl_core, dmsl_tx.
//
//   port group   dir   carries
//   s_axis_*     in    events: tuser operation, tdata rx_byte and enc_b_level
//   m_axis_*     out   motor updates and telemetry bytes, tlast on the frame end
//   cfg_*        in    register writes: 0 send_period_ms, 1 frame_header
//
// An event request is registered on accept and then decoded from the input
// register into the result register, which drives the result onto m_axis.
// Events are taken every cycle while the serializer is free; a tick that sends
// telemetry holds it for eight beats, so the next event waits for the last beat,
// while a motor update leaves no gap.
// Reset loads the counter and register defaults and clears the timer and frame position.
// A stall on m_axis backs up through the result register to s_axis_tready.
module dual_motor_serial_link import dmsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] enc_b_level, [15:9] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] left_pwm, [15:8] right_pwm, [16] left_reverse,
                                      // [17] right_reverse, [25:18] tx_byte, [31:26] zero
  output logic [0:0]  m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic       item_valid, item_take, item_blev;
  op_e        item_op;
  logic [7:0] item_rx;
  logic       res_valid, res_ready;
  res_t       res;
  kind_e      out_kind;
  logic [7:0] out_lp, out_rp, out_tx;
  logic       out_lr, out_rr;

  assign cfg_ready_o = 1'b1;

  dmsl_in_reg u_in_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (op_e'(s_axis_tuser)),
    .in_rx_byte_i   (s_axis_tdata[7:0]),
    .in_b_level_i   (s_axis_tdata[8]),
    .item_valid_o   (item_valid),
    .item_take_i    (item_take),
    .item_op_o      (item_op),
    .item_rx_byte_o (item_rx),
    .item_b_level_o (item_blev)
  );

  dmsl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_valid_i   (item_valid),
    .item_take_o    (item_take),
    .item_op_i      (item_op),
    .item_rx_byte_i (item_rx),
    .item_b_level_i (item_blev),
    .res_ready_i    (res_ready),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  dmsl_tx u_tx (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .res_valid_i         (res_valid),
    .res_ready_o         (res_ready),
    .res_i               (res),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .out_kind_o          (out_kind),
    .out_left_pwm_o      (out_lp),
    .out_right_pwm_o     (out_rp),
    .out_left_reverse_o  (out_lr),
    .out_right_reverse_o (out_rr),
    .out_tx_byte_o       (out_tx),
    .out_last_o          (m_axis_tlast)
  );

  // Pack the result beat
  assign m_axis_tdata = {6'd0, out_tx, out_rr, out_lr, out_rp, out_lp};
  assign m_axis_tuser = out_kind;

endmodule

>>> rtl/dmsl_in_reg.sv
// Input register of the dual motor serial link: holds one event request
// until the event core takes it. Depends on dmsl_pkg.
module dmsl_in_reg import dmsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  op_e        in_op_i,
  input  logic [7:0] in_rx_byte_i,
  input  logic       in_b_level_i,
  output logic       item_valid_o,
  input  logic       item_take_i,
  output op_e        item_op_o,
  output logic [7:0] item_rx_byte_o,
  output logic       item_b_level_o
);

  logic       valid_q, valid_d;
  op_e        op_q;
  logic [7:0] rx_q;
  logic       blev_q;
  logic       load;

  // Accept when empty or when the held request leaves this cycle
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= in_op_i;
      rx_q   <= in_rx_byte_i;
      blev_q <= in_b_level_i;
    end
  end

  assign item_valid_o   = valid_q;
  assign item_op_o      = op_q;
  assign item_rx_byte_o = rx_q;
  assign item_b_level_o = blev_q;

endmodule

>>> rtl/dmsl_core.sv
// Event core of the dual motor serial link: command frame decoder, encoder
// counters, millisecond timer and configuration registers. Depends on dmsl_pkg.
module dmsl_core import dmsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        item_valid_i,
  output logic        item_take_o,
  input  op_e         item_op_i,
  input  logic [7:0]  item_rx_byte_i,
  input  logic        item_b_level_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  logic [15:0] period_q, header_q;
  logic [7:0]  store_q [4];
  logic [2:0]  pos_q, pos_d;
  logic [15:0] left_q, left_d;
  logic [15:0] right_q, right_d;
  logic [15:0] ms_q, ms_d;
  logic [15:0] ms_inc;
  logic [15:0] chk_xor;
  logic [7:0]  sum;
  logic        store_we;
  logic        take;

  assign take        = item_valid_i && res_ready_i;
  assign item_take_o = take;

  assign sum     = store_q[0] + store_q[1] + store_q[2] + store_q[3];
  assign ms_inc  = (ms_q == MS_MAX) ? ms_q : ms_q + 16'd1;
  assign chk_xor = header_q ^ left_q ^ right_q;

  // Decode one event: next state and the result it causes
  always_comb begin
    pos_d       = pos_q;
    left_d      = left_q;
    right_d     = right_q;
    ms_d        = ms_q;
    store_we    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (take) begin
      case (item_op_i)
        OP_CMD_BYTE: begin
          if (pos_q < CHECKSUM_POS) begin
            store_we = 1'b1;
            pos_d    = pos_q + 3'd1;
          end else begin
            pos_d = '0;
            if (sum == item_rx_byte_i) begin
              res_valid_o         = 1'b1;
              res_o.kind          = KIND_MOTOR;
              res_o.left_pwm      = store_q[0];
              res_o.right_pwm     = store_q[1];
              res_o.left_reverse  = |store_q[2];
              res_o.right_reverse = |store_q[3];
            end
          end
        end
        OP_LEFT_EDGE: begin
          left_d = item_b_level_i ? left_q + 16'd1 : left_q - 16'd1;
        end
        OP_RIGHT_EDGE: begin
          right_d = item_b_level_i ? right_q + 16'd1 : right_q - 16'd1;
        end
        OP_MS_TICK: begin
          if (ms_inc < period_q) begin
            ms_d = ms_inc;
          end else begin
            ms_d        = '0;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_TELEM;
            res_o.frame = {chk_xor, right_q, left_q, header_q};
          end
        end
        default: begin
          ms_d = ms_q;
        end
      endcase
    end
  end

  // Hold state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      header_q <= HEADER_RESET;
      pos_q    <= '0;
      left_q   <= LEFT_RESET;
      right_q  <= RIGHT_RESET;
      ms_q     <= '0;
    end else begin
      pos_q   <= pos_d;
      left_q  <= left_d;
      right_q <= right_d;
      ms_q    <= ms_d;
      if (cfg_we_i && cfg_index_i == REG_SEND_PERIOD) begin
        period_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == REG_FRAME_HEADER) begin
        header_q <= cfg_data_i;
      end
    end
  end

  // Command bytes: contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[pos_q[1:0]] <= item_rx_byte_i;
    end
  end

endmodule

>>> rtl/dmsl_tx.sv
// Result register and byte serializer of the dual motor serial link: sends a
// motor update as one beat and a telemetry frame as eight. Depends on dmsl_pkg.
module dmsl_tx import dmsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  output logic        res_ready_o,
  input  res_t        res_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output kind_e       out_kind_o,
  output logic [7:0]  out_left_pwm_o,
  output logic [7:0]  out_right_pwm_o,
  output logic        out_left_reverse_o,
  output logic        out_right_reverse_o,
  output logic [7:0]  out_tx_byte_o,
  output logic        out_last_o
);

  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  res_t       res_q;
  logic       last_beat;
  logic       send;

  assign last_beat   = (res_q.kind == KIND_MOTOR) || (cnt_q == TELEM_LAST);
  assign send        = busy_q && out_ready_i;
  assign res_ready_o = !busy_q || (out_ready_i && last_beat);

  // Advance the byte counter, reload on a new result
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (send) begin
      if (last_beat) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
    if (res_valid_i && res_ready_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  // Drive the current beat
  assign out_valid_o         = busy_q;
  assign out_kind_o          = res_q.kind;
  assign out_left_pwm_o      = res_q.left_pwm;
  assign out_right_pwm_o     = res_q.right_pwm;
  assign out_left_reverse_o  = res_q.left_reverse;
  assign out_right_reverse_o = res_q.right_reverse;
  assign out_tx_byte_o       = (res_q.kind == KIND_TELEM) ? res_q.frame[{cnt_q, 3'b000} +: 8]
                                                          : 8'd0;
  assign out_last_o          = (res_q.kind == KIND_TELEM) && (cnt_q == TELEM_LAST);

endmodule
